FILE: rtl/clifford_tableau_gate_engine_core_macros.svh
// Assertion macros shared by the tableau gate engine RTL.
// Included by modules that carry concurrent assertions; needs no package.
`ifndef CLIFFORD_TABLEAU_GATE_ENGINE_CORE_MACROS_SVH
`define CLIFFORD_TABLEAU_GATE_ENGINE_CORE_MACROS_SVH

`ifndef SYNTH
`define CTGE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CTGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTGE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CTGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/ctge_pkg.sv
// Package for the tableau gate engine: sizes, op codes, payload structs
// and the command and status types between controller and datapath.
package ctge_pkg;

    localparam int QUBITS = 64;
    localparam int QFW = 6;
    localparam int DW = 64;
    localparam int QW = (QUBITS > 1) ? $clog2(QUBITS) : 1;
    localparam logic [QFW:0] QUBITS_LIM = (QFW + 1)'(QUBITS);

    typedef enum logic [3:0] {
        OP_CX      = 4'd0,
        OP_CY      = 4'd1,
        OP_CZ      = 4'd2,
        OP_SWAP    = 4'd3,
        OP_H_XY    = 4'd4,
        OP_H_YZ    = 4'd5,
        OP_H_XZ    = 4'd6,
        OP_X       = 4'd7,
        OP_WR_X    = 4'd8,
        OP_WR_Z    = 4'd9,
        OP_WR_SIGN = 4'd10,
        OP_RD_X    = 4'd11,
        OP_RD_Z    = 4'd12,
        OP_RD_SIGN = 4'd13
    } op_t;

    typedef enum logic [2:0] {
        CLS_DIRECT,
        CLS_READ,
        CLS_WRITE,
        CLS_GATE1,
        CLS_GATE2
    } req_class_t;

    typedef struct packed {
        logic [3:0]     op;
        logic [QFW-1:0] qubit_first;
        logic [QFW-1:0] qubit_second;
        logic           half_select;
        logic [DW-1:0]  write_data;
    } ctge_req_t;

    typedef struct packed {
        logic [DW-1:0] read_data;
        logic          same_qubit_error;
    } ctge_rsp_t;

    typedef struct packed {
        logic load;
        logic rd_b;
        logic cap_a;
        logic exec;
        logic wr_b;
        logic wr_row;
    } ctge_cmd_t;

    typedef struct packed {
        req_class_t in_class;
    } ctge_status_t;

endpackage

FILE: rtl/ctge_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
module ctge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ctge_datapath.sv
// Datapath of the tableau gate engine: request register, row memories,
// operand registers, sign words and the bitwise gate update. Uses ctge_pkg and ctge_ram.
module ctge_datapath
    import ctge_pkg::*;
(
    input  logic         clk,
    input  ctge_req_t    in_req,
    input  ctge_cmd_t    cmd,
    output ctge_status_t status,
    output ctge_rsp_t    rsp
);

    ctge_req_t            req_reg;
    logic [1:0][DW-1:0]   sign_reg;
    logic [1:0][DW-1:0]   ax_reg;
    logic [1:0][DW-1:0]   az_reg;
    logic [1:0][DW-1:0]   bx_reg;
    logic [1:0][DW-1:0]   bz_reg;

    logic [1:0][DW-1:0]   rx_rdata;
    logic [1:0][DW-1:0]   rz_rdata;
    logic [1:0][DW-1:0]   x_wdata;
    logic [1:0][DW-1:0]   z_wdata;
    logic [1:0]           x_we;
    logic [1:0]           z_we;
    logic [QW-1:0]        waddr;
    logic [QW-1:0]        raddr;

    logic [1:0][DW-1:0]   nax;
    logic [1:0][DW-1:0]   naz;
    logic [1:0][DW-1:0]   nbx;
    logic [1:0][DW-1:0]   nbz;
    logic [1:0][DW-1:0]   ns;

    logic                 in_qa_ok;
    logic                 in_qb_ok;
    logic                 req_qa_ok;

    // Classify the incoming request so the controller can pick its path.
    always_comb
    begin
        in_qa_ok = {1'b0, in_req.qubit_first} < QUBITS_LIM;
        in_qb_ok = {1'b0, in_req.qubit_second} < QUBITS_LIM;
        unique case (op_t'(in_req.op))
            OP_CX, OP_CY, OP_CZ, OP_SWAP:
            begin
                if (in_req.qubit_first == in_req.qubit_second)
                begin
                    status.in_class = CLS_DIRECT;
                end
                else if (in_qa_ok && in_qb_ok)
                begin
                    status.in_class = CLS_GATE2;
                end
                else
                begin
                    status.in_class = CLS_DIRECT;
                end
            end
            OP_H_XY, OP_H_YZ, OP_H_XZ, OP_X:
            begin
                status.in_class = in_qa_ok ? CLS_GATE1 : CLS_DIRECT;
            end
            OP_WR_X, OP_WR_Z:
            begin
                status.in_class = in_qa_ok ? CLS_WRITE : CLS_DIRECT;
            end
            OP_RD_X, OP_RD_Z:
            begin
                status.in_class = in_qa_ok ? CLS_READ : CLS_DIRECT;
            end
            default:
            begin
                status.in_class = CLS_DIRECT;
            end
        endcase
    end

    // Bitwise update of both halves; operand a comes from its register,
    // operand b straight from the memory read data.
    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            nax[h] = ax_reg[h];
            naz[h] = az_reg[h];
            nbx[h] = rx_rdata[h];
            nbz[h] = rz_rdata[h];
            ns[h]  = sign_reg[h];
            unique case (op_t'(req_reg.op))
                OP_CX:
                begin
                    ns[h]  = sign_reg[h] ^ (~(az_reg[h] ^ rx_rdata[h]) & ax_reg[h]
                             & rz_rdata[h]);
                    naz[h] = az_reg[h] ^ rz_rdata[h];
                    nbx[h] = rx_rdata[h] ^ ax_reg[h];
                end
                OP_CY:
                begin
                    naz[h] = az_reg[h] ^ rx_rdata[h];
                    ns[h]  = sign_reg[h] ^ (ax_reg[h] & naz[h] & (rx_rdata[h] ^ rz_rdata[h]));
                    naz[h] = naz[h] ^ rz_rdata[h];
                    nbx[h] = rx_rdata[h] ^ ax_reg[h];
                    nbz[h] = rz_rdata[h] ^ ax_reg[h];
                end
                OP_CZ:
                begin
                    ns[h]  = sign_reg[h] ^ (ax_reg[h] & rx_rdata[h] & (az_reg[h] ^ rz_rdata[h]));
                    naz[h] = az_reg[h] ^ rx_rdata[h];
                    nbz[h] = rz_rdata[h] ^ ax_reg[h];
                end
                OP_SWAP:
                begin
                    nax[h] = rx_rdata[h];
                    naz[h] = rz_rdata[h];
                    nbx[h] = ax_reg[h];
                    nbz[h] = az_reg[h];
                end
                OP_H_XY:
                begin
                    ns[h]  = sign_reg[h] ^ (~ax_reg[h] & az_reg[h]);
                    naz[h] = az_reg[h] ^ ax_reg[h];
                end
                OP_H_YZ:
                begin
                    ns[h]  = sign_reg[h] ^ (~az_reg[h] & ax_reg[h]);
                    nax[h] = ax_reg[h] ^ az_reg[h];
                end
                OP_H_XZ:
                begin
                    nax[h] = az_reg[h];
                    naz[h] = ax_reg[h];
                    ns[h]  = sign_reg[h] ^ (ax_reg[h] & az_reg[h]);
                end
                OP_X:
                begin
                    ns[h] = sign_reg[h] ^ az_reg[h];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Memory port control.
    always_comb
    begin
        raddr   = cmd.rd_b ? req_reg.qubit_second[QW-1:0] : req_reg.qubit_first[QW-1:0];
        waddr   = req_reg.qubit_first[QW-1:0];
        x_wdata = nax;
        z_wdata = naz;
        x_we    = '0;
        z_we    = '0;
        if (cmd.exec)
        begin
            x_we = 2'b11;
            z_we = 2'b11;
        end
        else if (cmd.wr_b)
        begin
            waddr   = req_reg.qubit_second[QW-1:0];
            x_wdata = bx_reg;
            z_wdata = bz_reg;
            x_we    = 2'b11;
            z_we    = 2'b11;
        end
        else if (cmd.wr_row)
        begin
            x_wdata = {2{req_reg.write_data}};
            z_wdata = {2{req_reg.write_data}};
            x_we[req_reg.half_select] = (op_t'(req_reg.op) == OP_WR_X);
            z_we[req_reg.half_select] = (op_t'(req_reg.op) == OP_WR_Z);
        end
    end

    for (genvar h = 0; h < 2; h++)
    begin : g_half
        ctge_ram #(
            .WIDTH (DW),
            .DEPTH (QUBITS)
        ) u_x_rows (
            .clk   (clk),
            .we    (x_we[h]),
            .waddr (waddr),
            .wdata (x_wdata[h]),
            .raddr (raddr),
            .rdata (rx_rdata[h])
        );

        ctge_ram #(
            .WIDTH (DW),
            .DEPTH (QUBITS)
        ) u_z_rows (
            .clk   (clk),
            .we    (z_we[h]),
            .waddr (waddr),
            .wdata (z_wdata[h]),
            .raddr (raddr),
            .rdata (rz_rdata[h])
        );
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_req;
        end
        if (cmd.load && (op_t'(in_req.op) == OP_WR_SIGN))
        begin
            sign_reg[in_req.half_select] <= in_req.write_data;
        end
        else if (cmd.exec)
        begin
            sign_reg <= ns;
        end
        if (cmd.cap_a)
        begin
            ax_reg <= rx_rdata;
            az_reg <= rz_rdata;
        end
        if (cmd.exec)
        begin
            bx_reg <= nbx;
            bz_reg <= nbz;
        end
    end

    // Result fields, valid while the controller shows the done strobe.
    always_comb
    begin
        req_qa_ok = {1'b0, req_reg.qubit_first} < QUBITS_LIM;
        rsp.same_qubit_error = (req_reg.op <= OP_SWAP)
                               && (req_reg.qubit_first == req_reg.qubit_second);
        unique case (op_t'(req_reg.op))
            OP_RD_X:
            begin
                rsp.read_data = req_qa_ok ? ax_reg[req_reg.half_select] : '0;
            end
            OP_RD_Z:
            begin
                rsp.read_data = req_qa_ok ? az_reg[req_reg.half_select] : '0;
            end
            OP_RD_SIGN:
            begin
                rsp.read_data = sign_reg[req_reg.half_select];
            end
            default:
            begin
                rsp.read_data = '0;
            end
        endcase
    end

endmodule

FILE: rtl/ctge_ctrl.sv
// Controller of the tableau gate engine: sequences memory reads, the update
// and write-back for each request. Uses ctge_pkg and the assertion macro header.
`include "clifford_tableau_gate_engine_core_macros.svh"

module ctge_ctrl
    import ctge_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  ctge_status_t status,
    output ctge_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_EXEC,
        S_WR_B,
        S_WR,
        S_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    req_class_t class_reg;
    req_class_t class_next;
    logic       busy_reg;
    logic       busy_next;
    logic       done_reg;
    logic       done_next;
    logic       accept;

    always_comb
    begin
        accept     = start && !busy_reg;
        state_next = state_reg;
        class_next = class_reg;
        unique case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (accept)
                begin
                    class_next = status.in_class;
                    unique case (status.in_class)
                        CLS_DIRECT: state_next = S_DONE;
                        CLS_WRITE:  state_next = S_WR;
                        default:    state_next = S_RD_A;
                    endcase
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_A:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                state_next = (class_reg == CLS_READ) ? S_DONE : S_EXEC;
            end
            S_EXEC:
            begin
                state_next = (class_reg == CLS_GATE2) ? S_WR_B : S_DONE;
            end
            S_WR_B, S_WR:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE) && (state_next != S_DONE);
        done_next = (state_next == S_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            class_reg <= CLS_DIRECT;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            class_reg <= class_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd.load   = accept;
        cmd.rd_b   = (state_reg == S_RD_B);
        cmd.cap_a  = (state_reg == S_RD_B);
        cmd.exec   = (state_reg == S_EXEC);
        cmd.wr_b   = (state_reg == S_WR_B);
        cmd.wr_row = (state_reg == S_WR);
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `CTGE_ASSERT_NEXT(a_accept_proceeds, clk, rst_n, accept, busy_reg || done_reg, "Accepted request was dropped.")
    `CTGE_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_reg, !busy_reg && (state_reg == S_DONE), "Done strobe outside the done state.")
    `CTGE_ASSERT_NEXT(a_two_qubit_writeback, clk, rst_n, (state_reg == S_EXEC) && (class_reg == CLS_GATE2), state_reg == S_WR_B, "Two-qubit gate skipped its second write-back.")
    `CTGE_ASSERT_NEXT(a_read_pair, clk, rst_n, state_reg == S_RD_A, state_reg == S_RD_B, "First row read not followed by second.")

endmodule

FILE: rtl/clifford_tableau_gate_engine_core.sv
// Top level of the tableau gate engine: controller plus datapath.
// Uses ctge_pkg, ctge_ctrl and ctge_datapath.
//
// A request is accepted on a clock edge where start is high and busy is low; its result
// appears on the result port for exactly one cycle with done high and cannot be held off.
// Path from accept to the done strobe: sign accesses, equal-qubit gates and out-of-range
// or unused ops go straight to S_DONE; a row write passes S_WR, a row read S_RD_A and
// S_RD_B, a single-qubit gate those and S_EXEC, and a two-qubit gate also S_WR_B.
// The row memories have one registered read port and one write port each: a gate reads
// its rows one qubit a cycle and writes them back one qubit a cycle. A new request may be
// accepted in the done cycle.
module clifford_tableau_gate_engine_core
    import ctge_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ctge_req_t request,
    output logic      busy,
    output logic      done,
    output ctge_rsp_t result
);

    ctge_cmd_t    cmd;
    ctge_status_t status;

    ctge_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ctge_datapath u_datapath (
        .clk    (clk),
        .in_req (request),
        .cmd    (cmd),
        .status (status),
        .rsp    (result)
    );

endmodule
